/* design/fhws_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fhws_pkg
// Shared types, constants and the CRC32C byte step for the flow hash worker
// selector.
// ----------------------------------------------------------------------------
package fhws_pkg;

  localparam int CRC_W      = 32;
  localparam int MSG_W      = 64;
  localparam int BYTE_W     = 8;
  localparam int CRC_CELLS  = MSG_W / BYTE_W;
  localparam int WORKER_W   = 8;
  localparam int ETYPE_W    = 16;
  localparam int PROTO_W    = 8;
  localparam int ADDR_W     = 32;
  localparam int PORT_W     = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // Remainder bits retired by one division cell; must divide CRC_W.
  localparam int DEF_MOD_BITS_PER_CELL = 4;

  localparam logic [CRC_W-1:0]   CRC32C_POLY     = 32'h82F6_3B78;
  localparam logic [ETYPE_W-1:0] FRAME_TYPE_IPV4 = 16'h0800;
  localparam logic [PROTO_W-1:0] PROTO_TCP       = 8'd6;
  localparam logic [PROTO_W-1:0] PROTO_UDP       = 8'd17;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WORKER_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_USE_DEST     = 1'b1;

  typedef struct packed {
    logic             discard;
    logic [CRC_W-1:0] crc;
    logic [MSG_W-1:0] msg;
  } crc_tok_t;

  typedef struct packed {
    logic                discard;
    logic [WORKER_W-1:0] rem;
    logic [CRC_W-1:0]    dividend;
  } mod_tok_t;

  // One reflected CRC32C byte update, bit by bit.
  function automatic logic [CRC_W-1:0] crc32c_byte(input logic [CRC_W-1:0] crc_in,
                                                    input logic [BYTE_W-1:0] data_b);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data_b};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC32C_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* design/fhws_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fhws_in_if / fhws_out_if
// Valid/ready channels for packet header items and worker decisions.
// ----------------------------------------------------------------------------
interface fhws_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] frame_type;
  logic [7:0]  ip_protocol;
  logic [31:0] source_address;
  logic [31:0] destination_address;
  logic [15:0] source_port;
  logic [15:0] destination_port;

  modport source (output valid, frame_type, ip_protocol, source_address,
                  destination_address, source_port, destination_port,
                  input ready);
  modport sink (input valid, frame_type, ip_protocol, source_address,
                destination_address, source_port, destination_port,
                output ready);
endinterface

interface fhws_out_if;
  logic       valid;
  logic       ready;
  logic       discard;
  logic [7:0] worker_index;

  modport source (output valid, discard, worker_index, input ready);
  modport sink (input valid, discard, worker_index, output ready);
endinterface

/* design/fhws_crc_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fhws_crc_cell
// One CRC32C cell: folds the top message byte into the running CRC and hands
// the shifted message on.
// ----------------------------------------------------------------------------
module fhws_crc_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  fhws_pkg::crc_tok_t up_tok,
  output logic               dn_valid,
  input  logic               dn_ready,
  output fhws_pkg::crc_tok_t dn_tok
);
  import fhws_pkg::*;

  logic     valid_r;
  crc_tok_t tok_r;
  crc_tok_t tok_nxt;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    tok_nxt.discard = up_tok.discard;
    tok_nxt.crc     = crc32c_byte(up_tok.crc, up_tok.msg[MSG_W-1 -: BYTE_W]);
    tok_nxt.msg     = up_tok.msg << BYTE_W;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      tok_r <= tok_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_tok   = tok_r;

endmodule

/* design/fhws_mod_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fhws_mod_cell
// One restoring-division cell: shifts a few dividend bits into the partial
// remainder and reduces it against the worker count.
// ----------------------------------------------------------------------------
module fhws_mod_cell #(
  parameter int BITS_PER_CELL = fhws_pkg::DEF_MOD_BITS_PER_CELL
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [fhws_pkg::WORKER_W-1:0] divisor,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  fhws_pkg::mod_tok_t            up_tok,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output fhws_pkg::mod_tok_t            dn_tok
);
  import fhws_pkg::*;

  logic     valid_r;
  mod_tok_t tok_r;
  mod_tok_t tok_nxt;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    logic [WORKER_W:0]   part;
    logic [WORKER_W-1:0] rem;
    logic [CRC_W-1:0]    div;
    rem = up_tok.rem;
    div = up_tok.dividend;
    for (int k = 0; k < BITS_PER_CELL; k++) begin
      part = {rem, div[CRC_W-1]};
      div  = div << 1;
      if (part >= {1'b0, divisor}) begin
        part = part - {1'b0, divisor};
      end
      rem = part[WORKER_W-1:0];
    end
    tok_nxt.discard  = up_tok.discard;
    tok_nxt.rem      = rem;
    tok_nxt.dividend = div;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      tok_r <= tok_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_tok   = tok_r;

endmodule

/* design/flow_hash_worker_select.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flow_hash_worker_select
// Classifies a packet header and picks a worker by CRC32C flow hash.
// ----------------------------------------------------------------------------
// Usage: header items arrive on in_item (valid/ready). Each item yields one
// result item on out_item: discard is set for anything but IPv4 TCP or UDP,
// otherwise worker_index is the CRC32C (zero initial value, no final XOR) of
// the selected address and port (plus two zero bytes) modulo worker_count. A
// worker count of zero, or a discarded packet, gives worker index zero.
// The datapath is a chain of cells: eight CRC cells, one per message byte,
// then 32 / MOD_BITS_PER_CELL division cells that each retire MOD_BITS_PER_CELL
// bits (four by default) of the remainder; one item is accepted every cycle
// while the receiver takes results. Each cell holds its own item and moves it
// on when the next cell is free, so a stalled receiver only fills the chain
// from the end; in_item.ready stays high while any cell still has room. The
// user must write the registers through cfg_we, cfg_index and cfg_wdata only
// while the chain is empty; the block does not enforce this. Synchronous reset
// empties every cell and sets worker_count to 1 and use_destination to 0.
// ----------------------------------------------------------------------------
module flow_hash_worker_select #(
  parameter int MOD_BITS_PER_CELL = fhws_pkg::DEF_MOD_BITS_PER_CELL
) (
  input  logic                            clk,
  input  logic                            rst_n,
  fhws_in_if.sink                         in_item,
  fhws_out_if.source                      out_item,
  input  logic                            cfg_we,
  input  logic [fhws_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fhws_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import fhws_pkg::*;

  localparam int MOD_CELLS = CRC_W / MOD_BITS_PER_CELL;

  logic [WORKER_W-1:0] worker_count_r;
  logic                use_dest_r;

  // Register writes; an index past the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      worker_count_r <= WORKER_W'(1);
      use_dest_r     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_WORKER_COUNT: worker_count_r <= cfg_wdata[WORKER_W-1:0];
        CFG_IDX_USE_DEST:     use_dest_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Classification and message assembly feed the first CRC cell directly.
  crc_tok_t crc_tok [CRC_CELLS+1];
  logic     crc_vld [CRC_CELLS+1];
  logic     crc_rdy [CRC_CELLS+1];

  logic                is_l4;
  logic [ADDR_W-1:0]   hash_addr;
  logic [PORT_W-1:0]   hash_port;

  always_comb begin
    is_l4 = (in_item.frame_type == FRAME_TYPE_IPV4) &&
            ((in_item.ip_protocol == PROTO_TCP) || (in_item.ip_protocol == PROTO_UDP));
    hash_addr = use_dest_r ? in_item.destination_address : in_item.source_address;
    hash_port = use_dest_r ? in_item.destination_port : in_item.source_port;
  end

  assign crc_tok[0] = '{discard: !is_l4,
                        crc:     '0,
                        msg:     {hash_addr, hash_port, {(MSG_W-ADDR_W-PORT_W){1'b0}}}};

  assign crc_vld[0]    = in_item.valid;
  assign in_item.ready = crc_rdy[0];

  for (genvar i = 0; i < CRC_CELLS; i++) begin : g_crc
    fhws_crc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (crc_vld[i]),
      .up_ready (crc_rdy[i]),
      .up_tok   (crc_tok[i]),
      .dn_valid (crc_vld[i+1]),
      .dn_ready (crc_rdy[i+1]),
      .dn_tok   (crc_tok[i+1])
    );
  end

  // The finished CRC becomes the dividend of the remainder chain.
  mod_tok_t mod_tok [MOD_CELLS+1];
  logic     mod_vld [MOD_CELLS+1];
  logic     mod_rdy [MOD_CELLS+1];

  assign mod_tok[0].discard  = crc_tok[CRC_CELLS].discard;
  assign mod_tok[0].rem      = '0;
  assign mod_tok[0].dividend = crc_tok[CRC_CELLS].crc;
  assign mod_vld[0]          = crc_vld[CRC_CELLS];
  assign crc_rdy[CRC_CELLS]  = mod_rdy[0];

  for (genvar j = 0; j < MOD_CELLS; j++) begin : g_mod
    fhws_mod_cell #(
      .BITS_PER_CELL (MOD_BITS_PER_CELL)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .divisor  (worker_count_r),
      .up_valid (mod_vld[j]),
      .up_ready (mod_rdy[j]),
      .up_tok   (mod_tok[j]),
      .dn_valid (mod_vld[j+1]),
      .dn_ready (mod_rdy[j+1]),
      .dn_tok   (mod_tok[j+1])
    );
  end

  // The last cell's register is the output register.
  assign out_item.valid        = mod_vld[MOD_CELLS];
  assign mod_rdy[MOD_CELLS]    = out_item.ready;
  assign out_item.discard      = mod_tok[MOD_CELLS].discard;
  assign out_item.worker_index = (mod_tok[MOD_CELLS].discard || (worker_count_r == '0)) ?
                                 '0 : mod_tok[MOD_CELLS].rem;

  // A delivered worker index always lies below a nonzero worker count.
  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_item.valid && (worker_count_r != '0)) |->
      (out_item.worker_index < worker_count_r))
    else $error("worker index not below worker count");

  // A discarded packet never names a worker.
  a_discard_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_item.valid && out_item.discard) |-> (out_item.worker_index == '0))
    else $error("discarded item carries a worker index");

  // With the output register empty the chain can always move, so input is open.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_item.valid |-> in_item.ready)
    else $error("input blocked while output register is empty");

  // Reset leaves no result behind.
  a_reset_empties: assert property (@(posedge clk)
    (rst_n && !$past(rst_n)) |-> !out_item.valid)
    else $error("result present right after reset");

endmodule
